/* rtl/htlp_pkg.sv */
// Shared types and constants for the linear-probing hash table.
package htlp_pkg;

    localparam int KEY_W      = 34;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;

    // Remainder unit: key is taken in HASH_BITS-bit digits, MSB first.
    localparam int HASH_BITS  = 6;
    localparam int HASH_STEPS = 6;
    localparam int KEY_PAD_W  = HASH_BITS * HASH_STEPS;
    localparam int HCNT_W     = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_START,
        S_HOME,
        S_SCAN,
        S_WRITE_A,
        S_WRITE_B,
        S_RESULT
    } t_state;

endpackage

/* rtl/htlp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module htlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/hash_table_linear_probing.sv */
// Steps: key mod TABLE_SIZE in HASH_BITS-bit digits, a read issue at the home slot,
//   probes at one per cycle, for an insert a write-back of the entry and any displaced occupant, result.
// Flow: one item at a time; input ready returns in the cycle after the result
//   is queued in the output register.
// Reset: synchronous; a clearing pass over every slot empties the table, ready low.
module hash_table_linear_probing #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_replace_mode_we,
    input  logic                            i_replace_mode,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_op,
    input  logic [htlp_pkg::KEY_W-1:0]      i_key,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [htlp_pkg::STATUS_W-1:0]   o_status,
    output logic [htlp_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic                            o_moved,
    output logic [htlp_pkg::SLOT_OUT_W-1:0] o_moved_slot
);

    import htlp_pkg::*;

    localparam int SW    = $clog2(TABLE_SIZE);
    localparam int CW    = $clog2(TABLE_SIZE + 1);
    localparam int SXW   = (SW > SLOT_OUT_W) ? SW : SLOT_OUT_W;
    localparam int MEM_W = 1 + SW + KEY_W;

    localparam logic [SW:0]   MOD_N = (SW + 1)'(TABLE_SIZE);
    localparam logic [SW-1:0] LAST  = SW'(TABLE_SIZE - 1);

    typedef struct packed {
        logic              occ;
        logic [SW-1:0]     home;
        logic [KEY_W-1:0]  key;
    } t_entry;

    t_state r_state, n_state;

    logic                   r_mode;
    logic [SW-1:0]          r_clr_addr;
    logic                   r_op;
    logic [KEY_W-1:0]       r_key;
    logic [KEY_PAD_W-1:0]   r_shift;
    logic [HCNT_W-1:0]      r_cnt;
    logic [SW-1:0]          r_home;
    logic [SW-1:0]          n_home;
    logic [SW-1:0]          r_eval;
    logic [SW-1:0]          w_next;
    logic [CW-1:0]          r_left;
    logic [SW-1:0]          r_found;
    logic                   r_displace;
    t_entry                 r_victim;
    logic [STATUS_W-1:0]    r_res_status;

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_o_status;
    logic [SLOT_OUT_W-1:0]  r_o_slot;
    logic                   r_o_moved;
    logic [SLOT_OUT_W-1:0]  r_o_mslot;

    logic                   w_mem_we;
    logic [SW-1:0]          w_mem_waddr;
    t_entry                 w_mem_wdata;
    logic [SW-1:0]          w_mem_raddr;
    logic [MEM_W-1:0]       w_rdata_raw;
    t_entry                 w_rdata;
    logic                   w_hit;
    logic                   w_push;
    logic [SW-1:0]          w_res_slot;
    logic [SW-1:0]          w_res_mslot;
    logic                   w_res_moved;
    logic [SXW-1:0]         w_slot_x;
    logic [SXW-1:0]         w_mslot_x;

    htlp_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = w_rdata_raw;
    assign w_next  = (r_eval == LAST) ? '0 : r_eval + 1'b1;

    // Remainder unit: fold HASH_BITS key bits into the running remainder.
    always_comb begin
        logic [SW:0] v_t;
        n_home = r_home;
        for (int i = 0; i < HASH_BITS; i++) begin
            v_t = {n_home, r_shift[KEY_PAD_W-1-i]};
            if (v_t >= MOD_N) begin
                v_t = v_t - MOD_N;
            end
            n_home = v_t[SW-1:0];
        end
    end

    always_comb begin
        if (r_op == OP_SEARCH) begin
            w_hit = w_rdata.occ && (w_rdata.key == r_key);
        end else begin
            w_hit = !w_rdata.occ;
        end
    end

    assign w_push = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_HASH;
            end
            S_HASH: begin
                if (r_cnt == HCNT_W'(HASH_STEPS - 1)) n_state = S_START;
            end
            S_START: begin
                n_state = (r_op == OP_SEARCH) ? S_SCAN : S_HOME;
            end
            S_HOME: begin
                n_state = w_rdata.occ ? S_SCAN : S_WRITE_A;
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = (r_op == OP_SEARCH) ? S_RESULT : S_WRITE_A;
                end else if (r_left == CW'(1)) begin
                    n_state = S_RESULT;
                end
            end
            S_WRITE_A: begin
                n_state = r_displace ? S_WRITE_B : S_RESULT;
            end
            S_WRITE_B: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_push) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the state machine: RAM port control and input ready
    always_comb begin
        o_in_ready  = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_found;
        w_mem_wdata = '{occ: 1'b1, home: r_home, key: r_key};
        w_mem_raddr = (r_state == S_START) ? r_home : w_next;
        case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                w_mem_wdata = '0;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_WRITE_A: begin
                w_mem_we = 1'b1;
                if (r_displace) begin
                    w_mem_wdata = r_victim;
                end
            end
            S_WRITE_B: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_home;
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_replace_mode_we) begin
                r_mode <= i_replace_mode;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op    <= i_op;
                r_key   <= i_key;
                r_shift <= KEY_PAD_W'(i_key);
                r_home  <= '0;
                r_cnt   <= '0;
            end
            S_HASH: begin
                r_shift <= r_shift << HASH_BITS;
                r_home  <= n_home;
                r_cnt   <= r_cnt + 1'b1;
            end
            S_START: begin
                r_eval     <= r_home;
                r_displace <= 1'b0;
                r_left     <= (r_op == OP_SEARCH) ? CW'(TABLE_SIZE) : CW'(TABLE_SIZE - 1);
            end
            S_HOME: begin
                r_eval <= w_next;
                if (!w_rdata.occ) begin
                    r_found      <= r_home;
                    r_res_status <= ST_INSERTED;
                end else if (r_mode && (w_rdata.home != r_home)) begin
                    // Misplaced occupant: evict it, then look for a free slot for it
                    r_displace <= 1'b1;
                    r_victim   <= w_rdata;
                end
            end
            S_SCAN: begin
                r_eval <= w_next;
                r_left <= r_left - 1'b1;
                if (w_hit) begin
                    r_found      <= r_eval;
                    r_res_status <= (r_op == OP_SEARCH) ? ST_FOUND : ST_INSERTED;
                end else if (r_left == CW'(1)) begin
                    r_res_status <= (r_op == OP_SEARCH) ? ST_MISSING : ST_FULL;
                end
            end
            default: begin
                r_eval <= r_eval;
            end
        endcase
    end

    always_comb begin
        w_res_moved = (r_res_status == ST_INSERTED) && r_displace;
        w_res_mslot = w_res_moved ? r_found : '0;
        if (r_res_status == ST_INSERTED || r_res_status == ST_FOUND) begin
            w_res_slot = w_res_moved ? r_home : r_found;
        end else begin
            w_res_slot = '0;
        end
    end

    assign w_slot_x  = SXW'(w_res_slot);
    assign w_mslot_x = SXW'(w_res_mslot);

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_o_status <= r_res_status;
            r_o_slot   <= w_slot_x[SLOT_OUT_W-1:0];
            r_o_moved  <= w_res_moved;
            r_o_mslot  <= w_mslot_x[SLOT_OUT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_slot       = r_o_slot;
    assign o_moved      = r_o_moved;
    assign o_moved_slot = r_o_mslot;

endmodule

/* rtl/htlp_checker.sv */
// Port-level checks for the hash table, bound to the top level.
module htlp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_replace_mode_we,
    input logic                            i_replace_mode,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            i_op,
    input logic [htlp_pkg::KEY_W-1:0]      i_key,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [htlp_pkg::STATUS_W-1:0]   o_status,
    input logic [htlp_pkg::SLOT_OUT_W-1:0] o_slot,
    input logic                            o_moved,
    input logic [htlp_pkg::SLOT_OUT_W-1:0] o_moved_slot
);

    import htlp_pkg::*;

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output beat valid after reset");

    // A waiting result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_slot)
            && $stable(o_moved) && $stable(o_moved_slot))
        else $error("result beat changed while stalled");

    // One item in flight: ready drops after an accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    // Only a successful insert can report a displaced occupant
    a_moved_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_moved |-> o_status == ST_INSERTED)
        else $error("moved set on a result that is not an insert");

    // Failures carry no slot information
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL || o_status == ST_MISSING) |->
            o_slot == '0 && !o_moved && o_moved_slot == '0)
        else $error("failed result carries a slot");

endmodule

bind hash_table_linear_probing htlp_checker u_htlp_checker (.*);
